// ===== hdl/tcw_pkg.sv =====
// ============================================================================
// Text console package
// Shared constants, command codes and controller states of the text console.
// ============================================================================
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int LOC_W  = 11;
    localparam int IDX_W  = 11;
    localparam int CMD_W  = 2;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0]        ATTR_RESET = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

    localparam int TAB_STOP = 8;

    // Register map: one word-aligned register.
    localparam int APB_ADDR_W = 3;
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ERASE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } state_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/text_console_char_writer.sv =====
// ============================================================================
// Text console character writer
// Text-mode terminal controller over a memory of attribute/character cells.
// ============================================================================
// The screen is a ROWS x COLUMNS array of 16-bit cells held in one RAM with a
// single write port. Clearing the screen writes every cell. A put that moves
// past the last row scrolls: each cell is copied up one row at one cell per
// cycle and the bottom row is blanked. After reset the block blanks the whole
// memory before it takes its first item; the attribute register can be
// written during that time. A new item is taken while the previous result
// still waits in the output register.
module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [CMD_W-1:0]      s_tuser,   // cmd[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // cursor_location[10:0], cell_data[26:11]

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COPY_LEN   = (ROWS - 1) * COLUMNS;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(COPY_LEN);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [COL_W:0]    COLS_X     = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROWS_X     = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]    TAB_X      = (COL_W + 1)'(TAB_STOP);
    localparam logic [COL_W:0]    TAB_MASK   = ~((COL_W + 1)'(TAB_STOP - 1));

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [7:0]          attr_reg, attr_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                copy_vld_reg, copy_vld_next;
    logic [LOC_W-1:0]    res_loc_reg, res_loc_next;
    logic [CELL_W-1:0]   res_data_reg, res_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_data_reg, m_data_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic [CHAR_W-1:0]   in_char;
    logic [IDX_W-1:0]    in_idx;
    cmd_t                in_cmd;

    logic [COL_W:0]      put_col;
    logic [ROW_W:0]      put_row;
    logic                put_print;
    logic                put_scroll;
    logic [COL_W-1:0]    put_col_n;
    logic [ROW_W-1:0]    put_row_n;
    logic [ADDR_W-1:0]   pos_cur;
    logic [ADDR_W-1:0]   pos_put;
    logic                out_free;
    logic                cfg_wr;

    assign in_char = s_tdata[7:0];
    assign in_idx  = s_tdata[18:8];
    assign in_cmd  = cmd_t'(s_tuser);

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);
    assign attr_next = cfg_wr ? pwdata[7:0] : attr_reg;
    assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, attr_reg} : 32'd0;

    // ---------------------------------------------------------- cursor math
    assign pos_cur = ADDR_W'(row_reg) * ROW_STRIDE + ADDR_W'(col_reg);

    always_comb begin
        put_col   = {1'b0, col_reg};
        put_row   = {1'b0, row_reg};
        put_print = 1'b0;
        case (in_char) inside
            CH_BACKSPACE: begin
                if (col_reg != '0) begin
                    put_col = put_col - 1'b1;
                end
            end
            CH_TAB: begin
                put_col = (put_col + TAB_X) & TAB_MASK;
            end
            CH_CR: begin
                put_col = '0;
            end
            CH_LF: begin
                put_col = '0;
                put_row = put_row + 1'b1;
            end
            [CH_PRINT_LO:CH_PRINT_HI]: begin
                put_print = 1'b1;
                put_col   = put_col + 1'b1;
            end
            default: begin
            end
        endcase
        if (put_col >= COLS_X) begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
        put_scroll = (put_row >= ROWS_X);
        put_col_n  = put_col[COL_W-1:0];
        put_row_n  = put_scroll ? ROW_W'(ROWS - 1) : put_row[ROW_W-1:0];
    end

    assign pos_put = ADDR_W'(put_row_n) * ROW_STRIDE + ADDR_W'(put_col_n);

    // ------------------------------------------------------------ sequencer
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cnt_next      = cnt_reg;
        copy_vld_next = 1'b0;
        res_loc_next  = res_loc_reg;
        res_data_next = res_data_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_cur;
        ram_wdata     = BLANK_CELL;
        ram_re        = 1'b0;
        ram_raddr     = cnt_reg + ROW_STRIDE;

        case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_data_next = '0;
                    case (in_cmd)
                        CMD_PUT: begin
                            ram_we       = put_print;
                            ram_wdata    = {attr_reg, in_char};
                            col_next     = put_col_n;
                            row_next     = put_row_n;
                            res_loc_next = LOC_W'(pos_put);
                            if (put_scroll) begin
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        CMD_CLEAR: begin
                            col_next     = '0;
                            row_next     = '0;
                            cnt_next     = '0;
                            res_loc_next = '0;
                            state_next   = ST_FILL;
                        end
                        CMD_ERASE: begin
                            ram_we = 1'b1;
                            if (col_reg != '0) begin
                                col_next     = col_reg - 1'b1;
                                res_loc_next = LOC_W'(pos_cur - 1'b1);
                                state_next   = ST_ERASE;
                            end else begin
                                res_loc_next = LOC_W'(pos_cur);
                                state_next   = ST_RESP;
                            end
                        end
                        CMD_READ: begin
                            res_loc_next = LOC_W'(pos_cur);
                            if (32'(in_idx) < CELL_COUNT) begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(in_idx);
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_ERASE: begin
                // The column is already decremented, so this is the left cell.
                ram_we     = 1'b1;
                state_next = ST_RESP;
            end
            ST_READ: begin
                res_data_next = ram_rdata;
                state_next    = ST_RESP;
            end
            ST_SCROLL: begin
                // Read one row down, and write the data read in the previous cycle.
                ram_re        = (cnt_reg != COPY_END);
                ram_we        = copy_vld_reg;
                ram_waddr     = cnt_reg - 1'b1;
                ram_wdata     = ram_rdata;
                copy_vld_next = (cnt_reg != COPY_END);
                if (cnt_reg == COPY_END) begin
                    state_next = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == LAST_ADDR) begin
                    cnt_next   = '0;
                    state_next = ST_RESP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, res_data_reg, res_loc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            col_reg      <= '0;
            row_reg      <= '0;
            attr_reg     <= ATTR_RESET;
            cnt_reg      <= '0;
            copy_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            attr_reg     <= attr_next;
            cnt_reg      <= cnt_next;
            copy_vld_reg <= copy_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_loc_reg  <= res_loc_next;
        res_data_reg <= res_data_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------- cell memory
    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_cells (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

endmodule

// ===== tb/tcw_console_checker.sv =====
// ============================================================================
// Text console checker
// Watches the command, result and register ports of the text console, keeps
// its own copy of the screen, cursor and attribute, and compares each result
// item field by field with the oldest predicted one.
// ============================================================================
module tcw_console_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [CMD_W-1:0]      s_tuser,   // cmd[1:0]

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // cursor_location[10:0], cell_data[26:11]

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,

    output int                    mismatch_count,
    output int                    outstanding,
    output int                    scroll_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = APB_ADDR_W'(4 * REG_TEXT_ATTR);

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_loc;
        logic [CELL_W-1:0] cell_word;
    } console_status_t;

    console_status_t   expected_status [$];
    logic [CELL_W-1:0] screen_mirror [CELLS];
    int unsigned       cursor_col;
    int unsigned       cursor_row;
    logic [7:0]        text_attr;
    console_status_t   predicted;
    console_status_t   received;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        scroll_count   = 0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Applies one command to the mirror and returns the status item it yields.
    task automatic advance_console(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                                   input logic [IDX_W-1:0] idx,
                                   output console_status_t status);
        int unsigned pos;
        int          i;
        status.cell_word = '0;
        pos = cursor_row * COLUMNS + cursor_col;
        case (cmd)
            CMD_PUT: begin
                if (ch == CH_BACKSPACE) begin
                    if (cursor_col != 0) cursor_col--;
                end else if (ch == CH_TAB) begin
                    cursor_col = (cursor_col + TAB_STOP) & ~(TAB_STOP - 1);
                end else if (ch == CH_CR) begin
                    cursor_col = 0;
                end else if (ch == CH_LF) begin
                    cursor_col = 0;
                    cursor_row++;
                end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
                    screen_mirror[pos] = {text_attr, ch};
                    cursor_col++;
                end
                if (cursor_col >= COLUMNS) begin
                    cursor_col = 0;
                    cursor_row++;
                end
                if (cursor_row >= ROWS) begin
                    for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                        screen_mirror[i] = screen_mirror[i + COLUMNS];
                    end
                    for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
                        screen_mirror[i] = BLANK_CELL;
                    end
                    cursor_row = ROWS - 1;
                    scroll_count++;
                end
            end
            CMD_CLEAR: begin
                for (i = 0; i < CELLS; i++) screen_mirror[i] = BLANK_CELL;
                cursor_col = 0;
                cursor_row = 0;
            end
            CMD_ERASE: begin
                screen_mirror[pos] = BLANK_CELL;
                // At column 0 only the cursor cell is blanked.
                if (cursor_col != 0) begin
                    screen_mirror[pos - 1] = BLANK_CELL;
                    cursor_col--;
                end
            end
            default: begin
                if (idx < CELLS) status.cell_word = screen_mirror[idx];
            end
        endcase
        status.cursor_loc = LOC_W'(cursor_row * COLUMNS + cursor_col);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) screen_mirror[i] = BLANK_CELL;
            cursor_col = 0;
            cursor_row = 0;
            text_attr  = ATTR_RESET;
            expected_status.delete();
            outstanding <= 0;
        end else begin
            // Results are handled first: one accepted at this edge is never
            // caused by an item accepted at the same edge.
            if (m_tvalid && m_tready) begin
                received = {m_tdata[26:11], m_tdata[10:0]} == '0 ? '0 : '0;
                received.cursor_loc = m_tdata[10:0];
                received.cell_word  = m_tdata[26:11];
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with no item waiting", m_tdata));
                end else begin
                    predicted = expected_status.pop_front();
                    if (received.cursor_loc !== predicted.cursor_loc) begin
                        report_mismatch($sformatf("cursor_location expected %0d, got %0d",
                                                  predicted.cursor_loc, received.cursor_loc));
                    end
                    if (received.cell_word !== predicted.cell_word) begin
                        report_mismatch($sformatf("cell_data expected 0x%04h, got 0x%04h",
                                                  predicted.cell_word, received.cell_word));
                    end
                    if (m_tdata[31:27] !== '0) begin
                        report_mismatch($sformatf("padding bits expected 0, got 0x%0h",
                                                  m_tdata[31:27]));
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) begin
                text_attr = pwdata[7:0];
            end
            if (s_tvalid && s_tready) begin
                advance_console(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[18:8], predicted);
                expected_status.push_back(predicted);
            end
            outstanding <= expected_status.size();
        end
    end

endmodule

// ===== tb/tb_text_console_char_writer.sv =====
// ============================================================================
// Text console character writer testbench
// Drives directed and random console commands with random idling, a long
// result stall and several attribute settings; a checker module predicts
// and compares every result item.
// ============================================================================
module tb_text_console_char_writer
    import tcw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = APB_ADDR_W'(4 * REG_TEXT_ATTR);

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = CMD_PUT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int   mismatch_count;
    int   outstanding;
    int   scroll_count;
    int   cmd_count [4];
    int   quiet_cycles  = 0;
    int   hold_left     = 0;
    bit   idle_on       = 1'b1;
    bit   hold_request  = 1'b0;

    always #6 aclk = ~aclk;

    text_console_char_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tcw_console_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .scroll_count   (scroll_count)
    );

    // Result side: random idling, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < 22);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pwrite && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding.", outstanding);
                $display("tb_text_console_char_writer: FAIL");
                $finish;
            end
        end
    end

    // Called and returns at a falling edge; s_tvalid is left high so that a
    // following item keeps it up without a second assignment in one step.
    task automatic send_command(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        while (idle_on && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, idx, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmd_count[int'(cmd)]++;
        @(negedge aclk);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ATTR_ADDR;
        pwdata  <= {24'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly printable text with line feeds, so the cursor reaches the bottom
    // row and scrolls; clears are rare because each one costs a full pass.
    task automatic run_random(input int count);
        int               roll;
        cmd_t             cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        repeat (count) begin
            roll = $urandom_range(0, 999);
            cmd  = CMD_PUT;
            ch   = CHAR_W'($urandom);
            idx  = IDX_W'($urandom);
            if (roll < 520) begin
                ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            end else if (roll < 620) begin
                ch = CH_LF;
            end else if (roll < 680) begin
                case ($urandom_range(0, 2))
                    0:       ch = CH_BACKSPACE;
                    1:       ch = CH_TAB;
                    default: ch = CH_CR;
                endcase
            end else if (roll < 720) begin
                // Any byte at all; most of them are ignored.
            end else if (roll < 840) begin
                cmd = CMD_ERASE;
            end else if (roll < 997) begin
                cmd = CMD_READ;
                if ($urandom_range(0, 4) != 0) begin
                    idx = IDX_W'($urandom_range(0, COLUMNS_DEF * ROWS_DEF - 1));
                end
            end else begin
                cmd = CMD_CLEAR;
            end
            send_command(cmd, ch, idx);
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // The block is still blanking its memory here; the register may be
        // written meanwhile.
        write_attribute(8'h1E);

        // Directed part: edges of the printable range, ignored bytes, every
        // control byte, erase-back with and without a column to its left,
        // and reads at and past the end of the screen.
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd0);
        send_command(CMD_PUT,   8'h41,            IDX_W'($urandom));
        send_command(CMD_PUT,   CH_PRINT_LO,      IDX_W'($urandom));
        send_command(CMD_PUT,   CH_PRINT_HI,      IDX_W'($urandom));
        send_command(CMD_PUT,   8'h1F,            IDX_W'($urandom));
        send_command(CMD_PUT,   8'h80,            IDX_W'($urandom));
        send_command(CMD_PUT,   8'hFF,            IDX_W'($urandom));
        send_command(CMD_PUT,   8'h00,            IDX_W'($urandom));
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd0);
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd2);
        send_command(CMD_PUT,   CH_BACKSPACE,     IDX_W'($urandom));
        send_command(CMD_ERASE, CHAR_W'($urandom), IDX_W'($urandom));
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd1);
        send_command(CMD_PUT,   CH_TAB,           IDX_W'($urandom));
        send_command(CMD_PUT,   CH_CR,            IDX_W'($urandom));
        send_command(CMD_PUT,   CH_BACKSPACE,     IDX_W'($urandom));
        send_command(CMD_PUT,   CH_LF,            IDX_W'($urandom));
        send_command(CMD_ERASE, CHAR_W'($urandom), IDX_W'($urandom));
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd1999);
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd2000);
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd2047);
        send_command(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
        send_command(CMD_READ,  CHAR_W'($urandom), 11'd0);
        wait_for_replies();

        // The sender keeps offering items while results are held back.
        write_attribute(8'h00);
        hold_request = 1'b1;
        run_random(300);
        wait_for_replies();

        idle_on = 1'b0;
        write_attribute(8'hFF);
        run_random(300);
        wait_for_replies();
        idle_on = 1'b1;

        write_attribute(8'($urandom_range(1, 254)));
        run_random(400);
        wait_for_replies();

        repeat (40) @(negedge aclk);
        $display("Covered %0d puts, %0d clears, %0d erase-backs and %0d reads",
                 cmd_count[int'(CMD_PUT)], cmd_count[int'(CMD_CLEAR)],
                 cmd_count[int'(CMD_ERASE)], cmd_count[int'(CMD_READ)]);
        $display("under four attribute values, with %0d scrolls and %0d mismatches.",
                 scroll_count, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("tb_text_console_char_writer: PASS");
        end else begin
            $display("tb_text_console_char_writer: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/text_console_char_writer.sv
tb/tcw_console_checker.sv
tb/tb_text_console_char_writer.sv
